@@ rtl/length_prefixed_nal_idr_scanner_macros.svh @@
`ifndef LENGTH_PREFIXED_NAL_IDR_SCANNER_MACROS_SVH
`define LENGTH_PREFIXED_NAL_IDR_SCANNER_MACROS_SVH

// Invariant checked at every edge out of reset
`define LPNIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies outcome in the next
`define LPNIS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/lpnis_pkg.sv @@
`default_nettype none

package lpnis_pkg;

  localparam int LEN_WIDTH = 32;

  localparam int PREFIX_W = 3;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 3'd4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_PREFIX_BYTES = 1'b0;

  localparam logic [4:0] TYPE_MASK = 5'h1F;
  localparam logic [4:0] TYPE_IDR  = 5'd5;

  localparam int VERDICT_W = 2;
  localparam logic [VERDICT_W-1:0] V_NOT_IDR = 2'd0;
  localparam logic [VERDICT_W-1:0] V_IDR     = 2'd1;
  localparam logic [VERDICT_W-1:0] V_BAD     = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       idr_hdr;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/lpnis_front.sv @@
`default_nettype none

module lpnis_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [7:0]           in_data,
  input  wire                 in_last,
  output logic                q_valid,
  input  wire                 q_ready,
  output lpnis_pkg::item_t    q_item
);
  import lpnis_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      in_item;

  // header type tagged on the way in; the back end only uses it in header phase
  always_comb begin
    in_item.data    = in_data;
    in_item.last    = in_last;
    in_item.idr_hdr = ((in_data[4:0] & TYPE_MASK) == TYPE_IDR);
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/lpnis_back.sv @@
`default_nettype none

module lpnis_back (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire [lpnis_pkg::PREFIX_W-1:0]       prefix_bytes,
  input  wire                                 q_valid,
  output logic                                q_ready,
  input  lpnis_pkg::item_t                    q_item,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [lpnis_pkg::VERDICT_W-1:0]     verdict
);
  import lpnis_pkg::*;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [1:0]             phase, phase_next;
  logic [1:0]             prefix_index, prefix_index_next;
  logic [LEN_WIDTH-1:0]   unit_length, unit_length_next;
  logic [LEN_WIDTH-1:0]   bytes_to_skip, bytes_to_skip_next;
  logic [VERDICT_W-1:0]   held, held_next;
  logic [VERDICT_W-1:0]   verdict_next;
  logic [1:0]             last_index;
  logic [LEN_WIDTH-1:0]   len_shift;
  logic                   pop;

  // a non-final word never produces a result, so it may pass a full output
  assign q_ready = !q_item.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // out-of-range settings: 0 acts as 1, 5 to 7 act as 4
  always_comb begin
    if (prefix_bytes == '0) begin
      last_index = 2'd0;
    end else if (prefix_bytes > PREFIX_W'(4)) begin
      last_index = 2'd3;
    end else begin
      last_index = 2'(prefix_bytes - PREFIX_W'(1));
    end
  end

  assign len_shift = LEN_WIDTH'({unit_length, q_item.data});

  always_comb begin
    phase_next         = phase;
    prefix_index_next  = prefix_index;
    unit_length_next   = unit_length;
    bytes_to_skip_next = bytes_to_skip;
    held_next          = held;
    unique case (phase)
      PH_LEN: begin
        unit_length_next = len_shift;
        if (prefix_index >= last_index) begin
          prefix_index_next = 2'd0;
          if (len_shift == '0) begin
            phase_next = PH_DONE;
            held_next  = V_BAD;
          end else begin
            phase_next = PH_HDR;
          end
        end else begin
          prefix_index_next = prefix_index + 2'd1;
        end
      end
      PH_HDR: begin
        if (q_item.idr_hdr) begin
          phase_next = PH_DONE;
          held_next  = V_IDR;
        end else begin
          bytes_to_skip_next = unit_length - LEN_WIDTH'(1);
          unit_length_next   = '0;
          phase_next = (unit_length == LEN_WIDTH'(1)) ? PH_LEN : PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_to_skip_next = bytes_to_skip - LEN_WIDTH'(1);
        if (bytes_to_skip == LEN_WIDTH'(1)) phase_next = PH_LEN;
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    // at a unit boundary the length accumulator is always clear
    if (phase_next == PH_DONE) begin
      verdict_next = held_next;
    end else if (phase_next == PH_LEN && prefix_index_next == 2'd0) begin
      verdict_next = V_NOT_IDR;
    end else begin
      verdict_next = V_BAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      prefix_index  <= 2'd0;
      unit_length   <= '0;
      bytes_to_skip <= '0;
      held          <= V_NOT_IDR;
      out_valid     <= 1'b0;
    end else begin
      if (pop && q_item.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (q_item.last) begin
          phase         <= PH_LEN;
          prefix_index  <= 2'd0;
          unit_length   <= '0;
          bytes_to_skip <= '0;
          held          <= V_NOT_IDR;
        end else begin
          phase         <= phase_next;
          prefix_index  <= prefix_index_next;
          unit_length   <= unit_length_next;
          bytes_to_skip <= bytes_to_skip_next;
          held          <= held_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) verdict <= verdict_next;
  end

`include "length_prefixed_nal_idr_scanner_macros.svh"

  `LPNIS_ASSERT(a_hdr_len,
                ((phase == PH_HDR) |-> (unit_length != '0)),
                "header phase with zero length")
  `LPNIS_ASSERT(a_skip_cnt,
                ((phase == PH_SKIP) |-> (bytes_to_skip != '0)),
                "skip phase with nothing left")
  `LPNIS_ASSERT(a_boundary,
                ((phase == PH_LEN && prefix_index == 2'd0) |-> (unit_length == '0)),
                "length not clear at unit boundary")
  `LPNIS_ASSERT_NEXT(a_result,
                     (pop && q_item.last),
                     (out_valid && phase == PH_LEN && prefix_index == 2'd0),
                     "final word did not yield a verdict")

endmodule

`default_nettype wire

@@ rtl/length_prefixed_nal_idr_scanner.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
// m_*       out  m_tvalid/m_tready  m_tdata[1:0] = verdict
// APB       in   psel/penable       prefix_bytes at address 0
//
// One byte per cycle sustained unless a final byte waits on a held verdict; each
// byte costs at most one length-field shift, header check or 32-bit skip-count
// decrement in the back end. The verdict follows the final byte through the queue
// word, then the output register; non-final bytes keep flowing while a verdict waits.
// rst is synchronous: prefix_bytes returns to 4 and any partial sample is dropped.
`default_nettype none

module length_prefixed_nal_idr_scanner (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [7:0]                          s_tdata,   // [7:0] data_byte
  input  wire                                s_tlast,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [7:0]                         m_tdata,   // [1:0] verdict, [7:2] zero
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [lpnis_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire [lpnis_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [lpnis_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready
);
  import lpnis_pkg::*;

  logic [PREFIX_W-1:0]  prefix_bytes;
  logic                 q_valid;
  logic                 q_ready;
  item_t                q_item;
  logic [VERDICT_W-1:0] verdict;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_PREFIX_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes <= PREFIX_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      prefix_bytes <= pwdata[PREFIX_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(prefix_bytes) : '0;

  lpnis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (s_tdata),
    .in_last  (s_tlast),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  lpnis_back u_back (
    .clk          (clk),
    .rst          (rst),
    .prefix_bytes (prefix_bytes),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .verdict      (verdict)
  );

  assign m_tdata = 8'(verdict);

endmodule

`default_nettype wire

@@ tb/length_prefixed_nal_idr_scanner_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_nal_idr_scanner_tb;
  import lpnis_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES = 50;
  localparam int NUM_PHASES = 8;
  localparam logic [APB_ADDR_W-1:0] ADDR_PREFIX = {REG_PREFIX_BYTES, 2'b00};
  // first index past the register list, must be ignored
  localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = 3'b100;

  typedef enum logic [1:0] {
    SCAN_LENGTH,
    SCAN_HEADER,
    SCAN_SKIP,
    SCAN_SETTLED
  } scan_state_t;

  class verdict_scoreboard;
    logic [PREFIX_W-1:0]  prefix_cfg;
    scan_state_t          state;
    logic [1:0]           len_idx;
    logic [LEN_WIDTH-1:0] unit_len;
    logic [LEN_WIDTH-1:0] skip_left;
    logic [VERDICT_W-1:0] held;
    logic [VERDICT_W-1:0] verdict_q[$];
    int errors;
    int bytes_taken;
    int samples;
    int n_idr;
    int n_plain;
    int n_bad;

    function new();
      prefix_cfg = PREFIX_RESET;
      errors = 0;
      bytes_taken = 0;
      samples = 0;
      n_idr = 0;
      n_plain = 0;
      n_bad = 0;
      clear_sample();
    endfunction

    function void clear_sample();
      state = SCAN_LENGTH;
      len_idx = '0;
      unit_len = '0;
      skip_left = '0;
      held = V_NOT_IDR;
    endfunction

    function void set_prefix(logic [PREFIX_W-1:0] v);
      prefix_cfg = v;
    endfunction

    function int field_bytes();
      if (prefix_cfg == 0) return 1;
      if (prefix_cfg > 4) return 4;
      return int'(prefix_cfg);
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [VERDICT_W-1:0] v;
      bytes_taken++;
      case (state)
        SCAN_LENGTH: begin
          unit_len = {unit_len[LEN_WIDTH-9:0], b};
          if (int'(len_idx) + 1 >= field_bytes()) begin
            len_idx = '0;
            if (unit_len == 0) begin
              state = SCAN_SETTLED;
              held = V_BAD;
            end else begin
              state = SCAN_HEADER;
            end
          end else begin
            len_idx = len_idx + 2'd1;
          end
        end
        SCAN_HEADER: begin
          if ((b[4:0] & TYPE_MASK) == TYPE_IDR) begin
            state = SCAN_SETTLED;
            held = V_IDR;
          end else begin
            skip_left = unit_len - 1;
            unit_len = '0;
            state = (skip_left == 0) ? SCAN_LENGTH : SCAN_SKIP;
          end
        end
        SCAN_SKIP: begin
          skip_left = skip_left - 1;
          if (skip_left == 0) state = SCAN_LENGTH;
        end
        default: ;
      endcase
      if (last) begin
        if (state == SCAN_SETTLED) v = held;
        else if (state == SCAN_LENGTH && len_idx == 0 && unit_len == 0) v = V_NOT_IDR;
        else v = V_BAD;
        verdict_q.push_back(v);
        samples++;
        clear_sample();
      end
    endfunction

    function void check_verdict(logic [7:0] tdata);
      logic [7:0] want;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict word, expected none, actual %02h", $time, tdata);
        errors++;
        return;
      end
      want = {6'b0, verdict_q.pop_front()};
      if (tdata !== want) begin
        $display("%0t: verdict mismatch, expected %02h, actual %02h", $time, want, tdata);
        errors++;
      end
      case (want[VERDICT_W-1:0])
        V_IDR:   n_idr++;
        V_BAD:   n_bad++;
        default: n_plain++;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  verdict_scoreboard sb = new();
  logic [7:0] sample_q[$];
  bit quiet_tail = 1'b0;
  bit hold_ask = 1'b0;
  int stall_count = 0;
  int phase_bytes;

  length_prefixed_nal_idr_scanner dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d verdicts outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("FAIL length_prefixed_nal_idr_scanner");
        $finish;
      end
    end
  end

  // result side back-pressure; one long hold when asked
  initial begin
    bit held_once;
    bit rdy;
    int n;
    held_once = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_ask && !held_once) begin
        held_once = 1'b1;
        rdy = 1'b0;
        n = HOLD_CYCLES;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        rdy = 1'b0;
        n = $urandom_range(1, 9);
      end else begin
        rdy = 1'b1;
        n = $urandom_range(1, 8);
      end
      @(negedge clk);
      m_tready <= rdy;
      repeat (n - 1) @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, last);
    phase_bytes++;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk);
    end
  endtask

  task automatic send_sample();
    for (int i = 0; i < sample_q.size(); i++) send_byte(sample_q[i], i == sample_q.size() - 1);
    sample_q.delete();
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_PREFIX) sb.set_prefix(data[PREFIX_W-1:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_prefix_reg();
    logic [APB_DATA_W-1:0] got;
    logic [APB_DATA_W-1:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_PREFIX;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    want = {{(APB_DATA_W - PREFIX_W){1'b0}}, sb.prefix_cfg};
    if (got !== want) begin
      $display("%0t: prefix_bytes readback mismatch, expected %08h, actual %08h",
               $time, want, got);
      sb.errors++;
    end
  endtask

  task automatic set_prefix_reg(input int v);
    logic [APB_DATA_W-1:0] word;
    wait_drained();
    word = $urandom();
    word[PREFIX_W-1:0] = v[PREFIX_W-1:0];
    apb_write(ADDR_PREFIX, word);
    check_prefix_reg();
  endtask

  // queue n bytes of v, most significant first
  task automatic push_bytes(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) sample_q.push_back(v[8*k +: 8]);
  endtask

  task automatic gen_sample(input int fbytes);
    int kind;
    int units;
    int zero_at;
    int len;
    int cut;
    logic [7:0] hdr;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      // plain noise
      repeat ($urandom_range(1, 12)) sample_q.push_back(8'($urandom()));
      return;
    end
    units = $urandom_range(1, 4);
    zero_at = (kind >= 70 && kind < 80) ? $urandom_range(0, units - 1) : -1;
    for (int u = 0; u < units; u++) begin
      if (u == zero_at) begin
        push_bytes(64'd0, fbytes);
        continue;
      end
      if (kind >= 90 && u == 0) begin
        // random length field, usually far beyond what follows
        repeat (fbytes) sample_q.push_back(8'($urandom()));
        len = 4;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        push_bytes(64'(len), fbytes);
      end
      if ($urandom_range(0, 4) == 0) begin
        hdr = {3'($urandom()), TYPE_IDR};
      end else begin
        hdr = 8'($urandom());
        while (hdr[4:0] == TYPE_IDR) hdr = 8'($urandom());
      end
      sample_q.push_back(hdr);
      repeat (len - 1) sample_q.push_back(8'($urandom()));
    end
    if (kind >= 80 && kind < 90) begin
      cut = $urandom_range(1, sample_q.size());
      while (sample_q.size() > cut) void'(sample_q.pop_back());
    end
  endtask

  initial begin
    int plan[NUM_PHASES];
    int fbytes;
    bit paused;
    plan = '{3, 2, 0, 7, 5, 1, 6, 4};
    paused = 1'b0;
    phase_bytes = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_prefix_reg();

    // four-byte length fields from reset
    push_bytes(64'hFF, 1);                  // ends inside length field
    send_sample();
    push_bytes(64'h0000_0000, 4);           // zero length
    send_sample();
    push_bytes(64'h0000_0002_4100, 6);      // ends on a unit boundary
    send_sample();

    stop_sending();
    set_prefix_reg(1);
    push_bytes(64'h01E5, 2);                // IDR with upper header bits set
    send_sample();
    push_bytes(64'h0305AA, 3);              // IDR beats a short unit
    send_sample();
    push_bytes(64'h02, 1);                  // ends before header
    send_sample();
    push_bytes(64'h040155, 3);              // ends inside payload
    send_sample();
    push_bytes(64'h010000, 3);              // zero length after a good unit
    send_sample();
    push_bytes(64'hFF1F, 2);                // largest one-byte length, cut short
    send_sample();

    for (int p = 0; p < NUM_PHASES; p++) begin
      stop_sending();
      set_prefix_reg(plan[p]);
      if (p == 2) begin
        apb_write(ADDR_SPARE, $urandom());
        check_prefix_reg();
      end
      if (p == 0) hold_ask = 1'b1;
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      fbytes = (plan[p] == 0) ? 1 : (plan[p] > 4) ? 4 : plan[p];
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        gen_sample(fbytes);
        send_sample();
        if (p == 4 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
          paused = 1'b1;
          stop_sending();
          while (sb.pending() != 0) @(posedge clk);
        end
      end
    end

    stop_sending();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Scanned %0d bytes in %0d samples over %0d prefix settings incl. out-of-range.",
             sb.bytes_taken, sb.samples, NUM_PHASES + 2);
    $display("Verdicts: %0d IDR, %0d not IDR, %0d malformed; %0d errors.",
             sb.n_idr, sb.n_plain, sb.n_bad, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS length_prefixed_nal_idr_scanner");
    end else begin
      $display("FAIL length_prefixed_nal_idr_scanner");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/lpnis_pkg.sv
rtl/lpnis_front.sv
rtl/lpnis_back.sv
rtl/length_prefixed_nal_idr_scanner.sv
tb/length_prefixed_nal_idr_scanner_tb.sv
